[design/poc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// poc_pkg
// Shared widths, defaults and control types of the order crossover block.
// ----------------------------------------------------------------------------
package poc_pkg;

	localparam int GENE_W        = 6;
	localparam int SIZE_W        = 7;
	localparam int MASK_W        = 64;
	localparam int MAX_GENES_DEF = 64;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd8;

	typedef logic [GENE_W-1:0] gene_t;
	typedef logic [SIZE_W-1:0] size_t;

	typedef struct packed {
		logic  clear;
		logic  set;
		gene_t set_value;
	} mask_ctl_t;

endpackage
`default_nettype wire

[design/poc_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// poc_in_if
// Parent load channel: one gene of each parent per item, plus cut points.
// ----------------------------------------------------------------------------
interface poc_in_if
	import poc_pkg::*;
();
	logic  valid;
	logic  ready;
	gene_t position;
	gene_t a_value;
	gene_t b_value;
	gene_t cut_low;
	gene_t cut_high;
	logic  load_done;

	modport source (
		output valid, position, a_value, b_value, cut_low, cut_high, load_done,
		input  ready
	);
	modport sink (
		input  valid, position, a_value, b_value, cut_low, cut_high, load_done,
		output ready
	);
endinterface
`default_nettype wire

[design/poc_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// poc_out_if
// Child result channel: one child gene per item.
// ----------------------------------------------------------------------------
interface poc_out_if
	import poc_pkg::*;
();
	logic  valid;
	logic  ready;
	gene_t child_position;
	gene_t child_value;
	logic  bad_request;
	logic  end_of_child;

	modport source (
		output valid, child_position, child_value, bad_request, end_of_child,
		input  ready
	);
	modport sink (
		input  valid, child_position, child_value, bad_request, end_of_child,
		output ready
	);
endinterface
`default_nettype wire

[design/poc_gene_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// poc_gene_ram
// One-write, one-read gene store with registered read data.
// ----------------------------------------------------------------------------
module poc_gene_ram
	import poc_pkg::*;
#(
	parameter int DEPTH = MAX_GENES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire gene_t                    wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output gene_t                         rdata
);

	gene_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[design/poc_mask_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// poc_mask_unit
// Segment value mask: marks parent A's copied values and tests a B gene.
// ----------------------------------------------------------------------------
module poc_mask_unit
	import poc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire mask_ctl_t ctl,
	input  wire gene_t     test_value,
	output logic           hit
);

	logic [MASK_W-1:0] mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (ctl.clear) begin
			mask_q <= '0;
		end else if (ctl.set) begin
			mask_q <= mask_q | (MASK_W'(1) << ctl.set_value);
		end
	end

	assign hit = mask_q[test_value];

endmodule
`default_nettype wire

[design/permutation_order_crossover.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// permutation_order_crossover
// Order crossover (OX1) of two parent permutations, gene by gene.
// ----------------------------------------------------------------------------
// One load item is taken per cycle while idle with the output register free.
// The item with load_done starts a build, during which parents.ready is low:
// A's copied segment is marked in the mask, then each child position is
// fetched and checked: a copied gene is sent from A, a scanned B gene is
// skipped on a mask hit or else sent, and a position left once B is used up
// gives an error item. The steps follow from the single registered read port
// of each gene store and the one shared mask test. Invalid cut points give
// one error item at once. A result waiting in the output register holds
// parents.ready low and stalls each sending step while child.ready stays low.
module permutation_order_crossover
	import poc_pkg::*;
#(
	parameter int MAX_GENES = MAX_GENES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire size_t          cfg_wdata,
	poc_in_if.sink              parents,
	poc_out_if.source           child
);

	localparam int    DEPTH = (MAX_GENES < MASK_W) ? MAX_GENES : MASK_W;
	localparam int    AW    = $clog2(DEPTH);
	localparam size_t CAP   = SIZE_W'(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MASK,
		ST_FETCH,
		ST_CHECK
	} state_t;

	state_t    state_q, st_d;
	size_t     size_q, n_q, idx_q, sp_q;
	gene_t     lo_q, hi_q;
	logic      rd_v_q;
	logic      ov_q;
	gene_t     opos_q, oval_q;
	logic      obad_q, oend_q;

	gene_t     a_rdata, b_rdata;
	logic      hit;
	mask_ctl_t mctl;

	logic      accept, ofree, in_seg, issue, last, cut_ok, wr_en;
	logic      a_re, b_re, emit, e_bad, e_end, sp_inc;
	gene_t     e_val, e_pos;
	size_t     n_lim;

	assign ofree  = !ov_q || child.ready;
	assign accept = parents.valid && parents.ready;
	assign n_lim  = (size_q > CAP) ? CAP : size_q;
	assign cut_ok = (parents.cut_low < parents.cut_high)
		&& ({1'b0, parents.cut_high} < n_lim);
	assign wr_en  = accept && ({1'b0, parents.position} < CAP);
	assign in_seg = ({1'b0, lo_q} <= idx_q) && (idx_q <= {1'b0, hi_q});
	assign issue  = (state_q == ST_MASK) && (idx_q <= {1'b0, hi_q});
	assign last   = (idx_q + 7'd1) == n_q;
	assign a_re   = issue || ((state_q == ST_FETCH) && in_seg);
	assign b_re   = (state_q == ST_FETCH) && !in_seg && (sp_q < n_q);

	assign parents.ready = (state_q == ST_IDLE) && ofree;

	assign mctl.clear     = accept && parents.load_done;
	assign mctl.set       = rd_v_q && (state_q == ST_MASK);
	assign mctl.set_value = a_rdata;

	poc_gene_ram #(.DEPTH(DEPTH)) u_a_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (parents.position[AW-1:0]),
		.wdata (parents.a_value),
		.re    (a_re),
		.raddr (idx_q[AW-1:0]),
		.rdata (a_rdata)
	);

	poc_gene_ram #(.DEPTH(DEPTH)) u_b_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (parents.position[AW-1:0]),
		.wdata (parents.b_value),
		.re    (b_re),
		.raddr (sp_q[AW-1:0]),
		.rdata (b_rdata)
	);

	poc_mask_unit u_mask (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mctl),
		.test_value (b_rdata),
		.hit        (hit)
	);

	always_comb begin
		st_d   = state_q;
		emit   = 1'b0;
		e_val  = a_rdata;
		e_bad  = 1'b0;
		e_pos  = idx_q[GENE_W-1:0];
		e_end  = last;
		sp_inc = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && parents.load_done) begin
					if (cut_ok) begin
						st_d = ST_MASK;
					end else begin
						emit  = 1'b1;
						e_val = '0;
						e_bad = 1'b1;
						e_pos = '0;
						e_end = 1'b1;
					end
				end
			end
			ST_MASK: begin
				if (!issue && !rd_v_q) begin
					st_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (in_seg || (sp_q < n_q)) begin
					st_d = ST_CHECK;
				end else if (ofree) begin
					emit  = 1'b1;
					e_val = '0;
					e_bad = 1'b1;
					st_d  = last ? ST_IDLE : ST_FETCH;
				end
			end
			ST_CHECK: begin
				if (in_seg) begin
					if (ofree) begin
						emit = 1'b1;
						st_d = last ? ST_IDLE : ST_FETCH;
					end
				end else if (hit) begin
					sp_inc = 1'b1;
					st_d   = ST_FETCH;
				end else if (ofree) begin
					emit   = 1'b1;
					e_val  = b_rdata;
					sp_inc = 1'b1;
					st_d   = last ? ST_IDLE : ST_FETCH;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q  <= SIZE_RESET;
			n_q     <= '0;
			idx_q   <= '0;
			sp_q    <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			rd_v_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= st_d;
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			rd_v_q <= issue;
			if (state_q == ST_IDLE && accept && parents.load_done) begin
				n_q   <= n_lim;
				lo_q  <= parents.cut_low;
				hi_q  <= parents.cut_high;
				idx_q <= {1'b0, parents.cut_low};
			end else if (issue) begin
				idx_q <= idx_q + 7'd1;
			end else if (state_q == ST_MASK && st_d == ST_FETCH) begin
				idx_q <= '0;
				sp_q  <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 7'd1;
			end
			if (sp_inc) begin
				sp_q <= sp_q + 7'd1;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (child.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			opos_q <= e_pos;
			oval_q <= e_val;
			obad_q <= e_bad;
			oend_q <= e_end;
		end
	end

	assign child.valid          = ov_q;
	assign child.child_position = opos_q;
	assign child.child_value    = oval_q;
	assign child.bad_request    = obad_q;
	assign child.end_of_child   = oend_q;

	a_busy_until_end: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !oend_q) |-> (state_q != ST_IDLE))
		else $error("child item pending before end with block idle");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH || state_q == ST_CHECK) |-> (sp_q <= n_q && idx_q < n_q))
		else $error("scan pointer or position beyond size");

	a_check_has_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH && st_d == ST_CHECK) |-> (a_re || b_re))
		else $error("check entered without a gene read");

	a_no_load_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MASK) |=> !$past(accept))
		else $error("item taken while building");

endmodule
`default_nettype wire
